// ----- rtl/split_hysteresis_branch_predictor_core_macros.svh -----
// Assertion macros used by the predictor's top-level RTL file.
`ifndef SPLIT_HYSTERESIS_BRANCH_PREDICTOR_CORE_MACROS_SVH
`define SPLIT_HYSTERESIS_BRANCH_PREDICTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SHBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SHBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/shbp_pkg.sv -----
// Package with table sizes, counter codes and controller/datapath interface types.
package shbp_pkg;

    localparam int DIR_IDX_BITS = 15;
    localparam int HYS_IDX_BITS = 13;
    localparam int CLR_BITS     = (DIR_IDX_BITS > HYS_IDX_BITS) ? DIR_IDX_BITS : HYS_IDX_BITS;
    localparam int DIR_DEPTH    = 1 << DIR_IDX_BITS;
    localparam int HYS_DEPTH    = 1 << HYS_IDX_BITS;

    localparam logic signed [1:0] HYS_RESET = -2'sd1;
    localparam logic signed [1:0] HYS_MIN   = -2'sd2;
    localparam logic signed [1:0] HYS_MAX   = 2'sd1;

    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_UPDATE  = 1'b1;

    typedef struct packed {
        logic                clear_we;
        logic [CLR_BITS-1:0] clear_addr;
        logic                capture;
        logic                commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ----- rtl/shbp_ctrl.sv -----
// Controller state machine: clearing pass, request acceptance and result commit.
module shbp_ctrl
    import shbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CLR_BITS-1:0] r_clr_cnt, n_clr_cnt;

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_cmd.clear_we   = (r_state == S_CLEAR);
    assign o_cmd.clear_addr = r_clr_cnt;
    assign o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit     = (r_state == S_LOOK) && i_status.out_free;

endmodule

// ----- rtl/shbp_datapath.sv -----
// Datapath: direction and hysteresis tables, request registers, update logic, result register.
module shbp_datapath
    import shbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_mode,
    input  logic [31:0] i_pc,
    input  logic        i_is_conditional,
    input  logic        i_taken,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_prediction
);

    logic              dir_mem [DIR_DEPTH];
    logic signed [1:0] hys_mem [HYS_DEPTH];

    logic                    r_mode, r_cond, r_taken;
    logic [DIR_IDX_BITS-1:0] r_didx;
    logic [HYS_IDX_BITS-1:0] r_hidx;
    logic                    r_dir_q;
    logic signed [1:0]       r_hys_q;
    logic                    r_out_valid, n_out_valid;
    logic                    r_pred;

    logic              upd;
    logic              dir_we;
    logic signed [1:0] n_ctr;

    always_comb begin
        if (r_taken) begin
            n_ctr = (r_hys_q == HYS_MAX) ? r_hys_q : r_hys_q + 2'sd1;
        end else begin
            n_ctr = (r_hys_q == HYS_MIN) ? r_hys_q : r_hys_q - 2'sd1;
        end
    end

    assign upd    = i_cmd.commit && r_cond && (r_mode == MODE_UPDATE);
    // A misprediction rewrites the direction bit from the counter's new sign.
    assign dir_we = upd && (r_taken != r_dir_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_we) begin
            dir_mem[i_cmd.clear_addr[DIR_IDX_BITS-1:0]] <= 1'b0;
            hys_mem[i_cmd.clear_addr[HYS_IDX_BITS-1:0]] <= HYS_RESET;
        end else begin
            if (dir_we) begin
                dir_mem[r_didx] <= ~n_ctr[1];
            end
            if (upd) begin
                hys_mem[r_hidx] <= n_ctr;
            end
        end
        if (i_cmd.capture) begin
            r_dir_q <= dir_mem[i_pc[DIR_IDX_BITS-1:0]];
            r_hys_q <= hys_mem[i_pc[HYS_IDX_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_cond  <= i_is_conditional;
            r_taken <= i_taken;
            r_didx  <= i_pc[DIR_IDX_BITS-1:0];
            r_hidx  <= i_pc[HYS_IDX_BITS-1:0];
        end
        if (i_cmd.commit) begin
            r_pred <= r_cond & r_dir_q;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_prediction      = r_pred;

endmodule

// ----- rtl/split_hysteresis_branch_predictor_core.sv -----
// Top level of the split hysteresis branch predictor: stream ports, controller and datapath.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata: pc[31:0], taken[32], zero[39:33]; tuser: mode[0], is_cond[1]
//  m_axis    out        tdata: prediction[0], zero[7:1]
//
// For each request the table read is registered in the accept cycle, and the counter
// update, direction rewrite and result load happen in the commit state, when the output register is free.
// After reset a clearing pass walks all 2**CLR_BITS addresses (32768 as configured) and writes both
// tables; s_axis_tready stays low throughout.
// A result waiting in the output register does not block acceptance; the update cycle
// waits only until that register is free.
`include "split_hysteresis_branch_predictor_core_macros.svh"

module split_hysteresis_branch_predictor_core
    import shbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // pc[31:0], taken[32], zero fill[39:33]
    input  logic [1:0]  s_axis_tuser,  // mode[0], is_conditional[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // prediction[0], zero fill[7:1]
);

    t_cmd    cmd;
    t_status status;
    logic    prediction;

    shbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    shbp_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_mode           (s_axis_tuser[0]),
        .i_pc             (s_axis_tdata[31:0]),
        .i_is_conditional (s_axis_tuser[1]),
        .i_taken          (s_axis_tdata[32]),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_prediction     (prediction)
    );

    assign m_axis_tdata = {7'd0, prediction};

    `SHBP_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, cmd.clear_we, !s_axis_tready, "request accepted during clearing pass")
    `SHBP_ASSERT_NEXT(a_busy_after_capture, i_clk, i_rst_n, cmd.capture, !s_axis_tready, "ready high while a request is in flight")
    `SHBP_ASSERT_NEXT(a_commit_gives_result, i_clk, i_rst_n, cmd.commit, m_axis_tvalid, "committed request produced no result")
    `SHBP_ASSERT_IMP(a_commit_needs_slot, i_clk, i_rst_n, cmd.commit, !m_axis_tvalid || m_axis_tready, "result register overwritten")

endmodule

// ----- bench/split_hysteresis_branch_predictor_core_checker.sv -----
// Checker for the branch predictor: models both tables and compares every returned prediction.
`timescale 1ns / 100ps

module split_hysteresis_branch_predictor_core_checker
    import shbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_tvalid,
    input  logic        i_req_tready,
    input  logic [39:0] i_req_tdata,  // pc[31:0], taken[32], zero fill[39:33]
    input  logic [1:0]  i_req_tuser,  // mode[0], is_conditional[1]
    input  logic        i_rsp_tvalid,
    input  logic        i_rsp_tready,
    input  logic [7:0]  i_rsp_tdata,  // prediction[0], zero fill[7:1]
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [31:0] pc;
        logic        prediction;
    } t_expected_prediction;

    logic                    direction_table [DIR_DEPTH];
    logic signed [1:0]       hysteresis_table [HYS_DEPTH];
    t_expected_prediction    expected_predictions [$];

    // Reads the direction bit of a conditional request and trains both tables on an update.
    function automatic logic lookup_and_train(input logic mode, input logic [31:0] pc,
                                              input logic is_cond, input logic taken);
        logic [DIR_IDX_BITS-1:0] dir_idx;
        logic [HYS_IDX_BITS-1:0] hys_idx;
        logic                    direction;
        logic signed [1:0]       counter;
        dir_idx = pc[DIR_IDX_BITS-1:0];
        hys_idx = pc[HYS_IDX_BITS-1:0];
        if (!is_cond) begin
            return 1'b0;
        end
        direction = direction_table[dir_idx];
        if (mode == MODE_UPDATE) begin
            counter = hysteresis_table[hys_idx];
            if (taken && counter != HYS_MAX) begin
                counter = counter + 2'sd1;
            end else if (!taken && counter != HYS_MIN) begin
                counter = counter - 2'sd1;
            end
            hysteresis_table[hys_idx] = counter;
            // The direction bit is only rewritten on a misprediction, from the new count.
            if (taken != direction) begin
                direction_table[dir_idx] = (counter >= 2'sd0);
            end
        end
        return direction;
    endfunction

    initial begin
        for (int i = 0; i < DIR_DEPTH; i++) begin
            direction_table[i] = 1'b0;
        end
        for (int i = 0; i < HYS_DEPTH; i++) begin
            hysteresis_table[i] = HYS_RESET;
        end
    end

    always @(posedge i_clk) begin
        t_expected_prediction entry;
        if (i_rst_n) begin
            if (i_req_tvalid && i_req_tready) begin
                entry.pc         = i_req_tdata[31:0];
                entry.prediction = lookup_and_train(i_req_tuser[0], i_req_tdata[31:0],
                                                    i_req_tuser[1], i_req_tdata[32]);
                expected_predictions.push_back(entry);
            end
            if (i_rsp_tvalid && i_rsp_tready) begin
                if (expected_predictions.size() == 0) begin
                    $display("%0t: unexpected prediction %0b with no request outstanding",
                             $time, i_rsp_tdata[0]);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    entry = expected_predictions.pop_front();
                    if (i_rsp_tdata[0] !== entry.prediction) begin
                        $display("%0t: prediction for pc %h: expected %0b, actual %0b",
                                 $time, entry.pc, entry.prediction, i_rsp_tdata[0]);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_pending = expected_predictions.size();
        end
    end

endmodule

// ----- bench/split_hysteresis_branch_predictor_core_tb.sv -----
// Testbench top for the branch predictor: clock, reset, request traffic and the verdict.
`timescale 1ns / 100ps

module split_hysteresis_branch_predictor_core_tb;
    import shbp_pkg::*;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;  // pc[31:0], taken[32], zero fill[39:33]
    logic [1:0]  s_axis_tuser  = '0;  // mode[0], is_conditional[1]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // prediction[0], zero fill[7:1]

    int fail_count;
    int pending;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int results_seen = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    always #5 i_clk = ~i_clk;

    split_hysteresis_branch_predictor_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    split_hysteresis_branch_predictor_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_tvalid (s_axis_tvalid),
        .i_req_tready (s_axis_tready),
        .i_req_tdata  (s_axis_tdata),
        .i_req_tuser  (s_axis_tuser),
        .i_rsp_tvalid (m_axis_tvalid),
        .i_rsp_tready (m_axis_tready),
        .i_rsp_tdata  (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side. Once a hundred results have come back, it refuses everything for a
    // long stretch so that the pipeline fills and the request side is pushed back.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen = results_seen + 1;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (results_seen >= 100 && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 300;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_request(input logic mode, input logic [31:0] pc,
                                input logic is_cond, input logic taken);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, taken, pc};
        s_axis_tuser  <= {is_cond, mode};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        logic [31:0] hot_pc [24];
        logic        hot_bias [24];
        logic [31:0] pc;
        logic        mode;
        logic        is_cond;
        logic        taken;
        int          pick;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk one counter through both limits and the direction rewrites.
        send_request(MODE_PREDICT, 32'h0000_0000, 1'b1, 1'b0);
        send_request(MODE_UPDATE,  32'h0000_0000, 1'b1, 1'b1);
        send_request(MODE_PREDICT, 32'h0000_0000, 1'b1, 1'b0);
        send_request(MODE_UPDATE,  32'h0000_0000, 1'b1, 1'b1);
        send_request(MODE_UPDATE,  32'h0000_0000, 1'b1, 1'b1);
        send_request(MODE_UPDATE,  32'h0000_0000, 1'b1, 1'b0);
        send_request(MODE_PREDICT, 32'h0000_0000, 1'b1, 1'b1);
        send_request(MODE_UPDATE,  32'h0000_0000, 1'b1, 1'b0);
        send_request(MODE_UPDATE,  32'h0000_0000, 1'b1, 1'b0);
        send_request(MODE_UPDATE,  32'h0000_0000, 1'b1, 1'b0);
        send_request(MODE_PREDICT, 32'h0000_0000, 1'b1, 1'b1);
        // Top of the address space, and branches that are not conditional.
        send_request(MODE_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1);
        send_request(MODE_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_request(MODE_UPDATE,  32'hFFFF_FFFF, 1'b0, 1'b1);
        send_request(MODE_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_request(MODE_UPDATE,  32'h0000_0000, 1'b0, 1'b1);
        // Addresses that alias on the direction entry or only on the shared counter.
        send_request(MODE_UPDATE,  32'h0000_2000, 1'b1, 1'b1);
        send_request(MODE_UPDATE,  32'h0000_2000, 1'b1, 1'b1);
        send_request(MODE_UPDATE,  32'h0000_0000, 1'b1, 1'b1);
        send_request(MODE_PREDICT, 32'hFFFF_8000, 1'b1, 1'b0);
        send_request(MODE_PREDICT, 32'h0000_2000, 1'b1, 1'b0);
        send_request(MODE_UPDATE,  32'h8000_7FFF, 1'b1, 1'b0);
        send_request(MODE_PREDICT, 32'h7FFF_7FFF, 1'b1, 1'b1);

        // A small set of hot branches keeps counters moving between their limits;
        // some of them share a counter but not a direction entry.
        for (int i = 0; i < 24; i++) begin
            hot_pc[i]   = (i < 16) ? $urandom : (hot_pc[i - 16] ^ 32'h0000_2000);
            hot_bias[i] = 1'($urandom_range(0, 1));
        end

        for (int n = 0; n < 1800; n++) begin
            case (n / 450)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 69; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            pick = $urandom_range(0, 23);
            if ($urandom_range(0, 99) < 75) begin
                pc    = $urandom;
                pc    = {pc[31:DIR_IDX_BITS], hot_pc[pick][DIR_IDX_BITS-1:0]};
                taken = ($urandom_range(0, 99) < 80) ? hot_bias[pick] : !hot_bias[pick];
            end else begin
                pc    = $urandom;
                taken = 1'($urandom_range(0, 1));
            end
            mode    = ($urandom_range(0, 99) < 55) ? MODE_UPDATE : MODE_PREDICT;
            is_cond = ($urandom_range(0, 99) < 88);
            send_request(mode, pc, is_cond, taken);
        end
        s_axis_tvalid <= 1'b0;

        // Waiting on the clock lets the checker record the last request before the count is read.
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog that lets the clearing pass and the traffic finish and otherwise ends the run as failed.
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/shbp_pkg.sv
rtl/shbp_ctrl.sv
rtl/shbp_datapath.sv
rtl/split_hysteresis_branch_predictor_core.sv
bench/split_hysteresis_branch_predictor_core_checker.sv
bench/split_hysteresis_branch_predictor_core_tb.sv
